// ===== src/hsc_pkg.sv =====
package hsc_pkg;

  // Sync mode, also reported in every result word.
  typedef enum logic [1:0] {
    MODE_SEARCH  = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_OPERATE = 2'd2
  } mode_t;

  // Event codes carried by the action field.
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_START  = 2'd1,
    ACT_TIMER  = 2'd2,
    ACT_PACKET = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATE_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATE_WAIT    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0]  LOSS_LIMIT_RST      = 8'd5;
  localparam logic [23:0] SEARCH_PERIOD_RST   = 24'd3277;
  localparam logic [23:0] ACK_WAIT_PERIOD_RST = 24'd33;
  localparam logic [23:0] OPERATE_PERIOD_RST  = 24'd328;
  localparam logic [23:0] OPERATE_WAIT_RST    = 24'd295;

  localparam logic [7:0] LOSS_MAX = 8'd255;

  // One result word of radio commands.
  typedef struct packed {
    logic        set_channel;
    logic [7:0]  channel;
    logic        start_rx;
    logic        stop_rx;
    logic        clear_timer;
    logic        load_compare;
    logic [23:0] compare_value;
    logic        send_reply;
    mode_t       mode;
  } result_t;

endpackage

// ===== src/hsc_outq.sv =====
module hsc_outq
  import hsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop_ready,
  output logic    head_valid,
  output result_t head
);

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    data0;
  result_t    data1;
  logic       pop;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head       = data0;
  assign pop        = head_valid && pop_ready;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (!push && pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Two-entry buffer, head in data0.
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        data0 <= push_data;
      end else begin
        data1 <= push_data;
      end
    end else if (push && pop) begin
      if (count == 2'd1) begin
        data0 <= push_data;
      end else begin
        data0 <= data1;
        data1 <= push_data;
      end
    end else if (pop) begin
      data0 <= data1;
    end
  end

endmodule

// ===== src/hsc_core.sv =====
module hsc_core
  import hsc_pkg::*;
#(
  parameter int SEARCH_TABLE_SIZE = 9,
  parameter int HOP_TABLE_SIZE    = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [1:0]            action,
  input  logic [3:0]            slot_index,
  input  logic [7:0]            load_channel,
  input  logic                  payload_ok,
  input  logic [7:0]            switch_count,
  input  logic [7:0]            hop_ch0,
  input  logic [7:0]            hop_ch1,
  input  logic [7:0]            hop_ch2,
  output result_t               result
);

  localparam int MAX_SZ = (SEARCH_TABLE_SIZE > HOP_TABLE_SIZE) ?
                          SEARCH_TABLE_SIZE : HOP_TABLE_SIZE;
  localparam int IDX_W  = (MAX_SZ > 1) ? $clog2(MAX_SZ) : 1;
  localparam int SW     = $clog2(SEARCH_TABLE_SIZE);
  localparam int HW     = (HOP_TABLE_SIZE > 1) ? $clog2(HOP_TABLE_SIZE) : 1;
  localparam int MOD_W  = IDX_W + 3;

  // Configuration registers.
  logic [7:0]  loss_limit;
  logic [23:0] search_period;
  logic [23:0] ack_wait_period;
  logic [23:0] operate_period;
  logic [23:0] operate_wait_period;

  // Control state.
  mode_t            sync_mode, sync_mode_next;
  logic             rx_enabled, rx_enabled_next;
  logic [IDX_W-1:0] hop_index, hop_index_next;
  logic [7:0]       loss_count, loss_count_next;
  logic [7:0]       switch_countdown, switch_countdown_next;
  logic             table_pending, table_pending_next;
  logic             heard_flag, heard_flag_next;
  logic             ack_wait_flag, ack_wait_flag_next;

  // Tables, undefined until written.
  logic [7:0] hop_table    [HOP_TABLE_SIZE];
  logic [7:0] next_table   [HOP_TABLE_SIZE];
  logic [7:0] search_table [SEARCH_TABLE_SIZE];
  logic [7:0] payload      [3];

  logic             search_wr;
  logic             hop_wr_payload;
  logic             hop_wr_copy;
  logic             next_wr;
  action_t          act;
  logic [IDX_W:0]   search_sum;
  logic [IDX_W-1:0] search_inc;
  logic [HW-1:0]    hop_mod_idx;
  logic [HW-1:0]    hop_mod_inc;
  logic             copy_due;
  logic [7:0]       hop_read;

  // Reduce a hop index into the hop table range by conditional subtraction.
  function automatic logic [HW-1:0] hop_mod(input logic [IDX_W-1:0] idx);
    logic [MOD_W-1:0] r;
    logic [MOD_W-1:0] step;
    r = MOD_W'(idx);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      step = MOD_W'(HOP_TABLE_SIZE) << k;
      if (r >= step) begin
        r = r - step;
      end
    end
    return HW'(r);
  endfunction

  assign payload[0] = hop_ch0;
  assign payload[1] = hop_ch1;
  assign payload[2] = hop_ch2;
  assign act        = action_t'(action);

  // Next search slot, wrapping at the table size.
  assign search_sum = {1'b0, hop_index} + (IDX_W + 1)'(1);
  assign search_inc = (search_sum >= (IDX_W + 1)'(SEARCH_TABLE_SIZE)) ?
                      IDX_W'(search_sum - (IDX_W + 1)'(SEARCH_TABLE_SIZE)) :
                      IDX_W'(search_sum);

  // Hop position in operate mode and its successor.
  assign hop_mod_idx = hop_mod(hop_index);
  assign hop_mod_inc = (hop_mod_idx == HW'(HOP_TABLE_SIZE - 1)) ? '0 :
                       hop_mod_idx + HW'(1);
  // A pending table that is applied in this step is also the one read.
  assign copy_due    = (switch_countdown == 8'd0) && table_pending;
  assign hop_read    = copy_due ? next_table[hop_mod_idx] : hop_table[hop_mod_idx];

  // Event decoder: next state and the result word.
  always_comb begin
    sync_mode_next        = sync_mode;
    rx_enabled_next       = rx_enabled;
    hop_index_next        = hop_index;
    loss_count_next       = loss_count;
    switch_countdown_next = switch_countdown;
    table_pending_next    = table_pending;
    heard_flag_next       = heard_flag;
    ack_wait_flag_next    = ack_wait_flag;
    search_wr             = 1'b0;
    hop_wr_payload        = 1'b0;
    hop_wr_copy           = 1'b0;
    next_wr               = 1'b0;
    result                = '0;

    if (accept) begin
      unique case (act)
        ACT_LOAD: begin
          if ({1'b0, slot_index} < 5'(SEARCH_TABLE_SIZE)) begin
            search_wr = 1'b1;
          end
        end
        ACT_START: begin
          sync_mode_next       = MODE_SEARCH;
          result.load_compare  = 1'b1;
          result.compare_value = search_period;
          result.start_rx      = 1'b1;
          rx_enabled_next      = 1'b1;
        end
        ACT_TIMER: begin
          if (sync_mode == MODE_SEARCH) begin
            // Alternate between listening and idle on each expiry.
            result.clear_timer = 1'b1;
            if (rx_enabled) begin
              rx_enabled_next = 1'b0;
              result.stop_rx  = 1'b1;
            end else begin
              rx_enabled_next    = 1'b1;
              hop_index_next     = search_inc;
              result.set_channel = 1'b1;
              result.channel     = search_table[search_inc[SW-1:0]];
              result.start_rx    = 1'b1;
            end
          end else if (sync_mode == MODE_ACK) begin
            result.stop_rx       = 1'b1;
            sync_mode_next       = MODE_OPERATE;
            result.clear_timer   = 1'b1;
            result.load_compare  = 1'b1;
            result.compare_value = operate_wait_period;
            heard_flag_next      = 1'b1;
            ack_wait_flag_next   = 1'b1;
          end else begin
            // Count down to the table switch, then apply the pending table.
            if (switch_countdown != 8'd0) begin
              switch_countdown_next = switch_countdown - 8'd1;
            end else if (table_pending) begin
              hop_wr_copy        = 1'b1;
              table_pending_next = 1'b0;
            end
            if (loss_count >= loss_limit) begin
              sync_mode_next       = MODE_SEARCH;
              result.clear_timer   = 1'b1;
              result.load_compare  = 1'b1;
              result.compare_value = search_period;
              heard_flag_next      = 1'b0;
              hop_index_next       = '0;
            end else if (heard_flag) begin
              result.clear_timer   = 1'b1;
              result.load_compare  = 1'b1;
              result.compare_value = operate_period;
              result.stop_rx       = !ack_wait_flag;
              result.set_channel   = 1'b1;
              result.channel       = hop_read;
              hop_index_next       = IDX_W'(hop_mod_inc);
              ack_wait_flag_next   = 1'b0;
            end else if (loss_count != LOSS_MAX) begin
              loss_count_next = loss_count + 8'd1;
            end
            result.start_rx = 1'b1;
          end
        end
        ACT_PACKET: begin
          if (payload_ok) begin
            if ((sync_mode == MODE_SEARCH) && (switch_count == 8'd0)) begin
              hop_wr_payload = 1'b1;
            end else if (sync_mode == MODE_OPERATE) begin
              switch_countdown_next = switch_count;
              if (switch_count != 8'd0) begin
                table_pending_next = 1'b1;
                next_wr            = 1'b1;
              end else begin
                hop_wr_payload = 1'b1;
              end
            end
            result.send_reply = 1'b1;
          end
          sync_mode_next       = MODE_ACK;
          result.clear_timer   = 1'b1;
          result.load_compare  = 1'b1;
          result.compare_value = ack_wait_period;
          loss_count_next      = 8'd0;
        end
        default: begin
        end
      endcase
    end
    result.mode = sync_mode_next;
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_mode        <= MODE_SEARCH;
      rx_enabled       <= 1'b0;
      hop_index        <= '0;
      loss_count       <= 8'd0;
      switch_countdown <= 8'd0;
      table_pending    <= 1'b0;
      heard_flag       <= 1'b0;
      ack_wait_flag    <= 1'b0;
    end else begin
      sync_mode        <= sync_mode_next;
      rx_enabled       <= rx_enabled_next;
      hop_index        <= hop_index_next;
      loss_count       <= loss_count_next;
      switch_countdown <= switch_countdown_next;
      table_pending    <= table_pending_next;
      heard_flag       <= heard_flag_next;
      ack_wait_flag    <= ack_wait_flag_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_limit          <= LOSS_LIMIT_RST;
      search_period       <= SEARCH_PERIOD_RST;
      ack_wait_period     <= ACK_WAIT_PERIOD_RST;
      operate_period      <= OPERATE_PERIOD_RST;
      operate_wait_period <= OPERATE_WAIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LOSS_LIMIT:      loss_limit          <= cfg_data[7:0];
        CFG_SEARCH_PERIOD:   search_period       <= cfg_data;
        CFG_ACK_WAIT_PERIOD: ack_wait_period     <= cfg_data;
        CFG_OPERATE_PERIOD:  operate_period      <= cfg_data;
        CFG_OPERATE_WAIT:    operate_wait_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Channel tables.
  always_ff @(posedge clk) begin
    if (search_wr) begin
      search_table[slot_index[SW-1:0]] <= load_channel;
    end
    for (int i = 0; i < HOP_TABLE_SIZE; i++) begin
      if (hop_wr_payload) begin
        hop_table[i] <= payload[i];
      end else if (hop_wr_copy) begin
        hop_table[i] <= next_table[i];
      end
      if (next_wr) begin
        next_table[i] <= payload[i];
      end
    end
  end

endmodule

// ===== src/receiver_hop_sync_controller.sv =====
// Receiver hop synchronizer.
// Input channel (in_valid / in_ready): one event word per transfer, selected by
// action: load a search channel, start the search, timer expiry, or packet
// received with its switch countdown and three hop channels.
// Output channel (out_valid / out_ready): exactly one word of radio commands
// per event word, in order, with the mode after the event.
// Configuration: cfg_write with cfg_index and cfg_data sets loss limit and
// timer periods; write only while no event is in flight.
// Each accepted event's result word is registered into the output buffer.
// The event decode is a single pass over a few registers, so one event is
// taken every cycle unless in_ready is low. Results go into a two-word output
// buffer; while the sink stalls, input is still accepted until both words are
// held, then in_ready drops. Reset clears mode to search, all counters and
// flags, restores register defaults and empties the output buffer. Channel
// tables are not cleared and must be loaded before they are read.
module receiver_hop_sync_controller
  import hsc_pkg::*;
#(
  parameter int SEARCH_TABLE_SIZE = 9,
  parameter int HOP_TABLE_SIZE    = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [3:0]            slot_index,
  input  logic [7:0]            load_channel,
  input  logic                  payload_ok,
  input  logic [7:0]            switch_count,
  input  logic [7:0]            hop_ch0,
  input  logic [7:0]            hop_ch1,
  input  logic [7:0]            hop_ch2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  set_channel,
  output logic [7:0]            channel,
  output logic                  start_rx,
  output logic                  stop_rx,
  output logic                  clear_timer,
  output logic                  load_compare,
  output logic [23:0]           compare_value,
  output logic                  send_reply,
  output logic [1:0]            mode
);

  logic    accept;
  logic    full;
  result_t step_result;
  result_t head;

  assign in_ready = !full;
  assign accept   = in_valid && !full;

  // Event decode and state.
  hsc_core #(
    .SEARCH_TABLE_SIZE (SEARCH_TABLE_SIZE),
    .HOP_TABLE_SIZE    (HOP_TABLE_SIZE)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .action       (action),
    .slot_index   (slot_index),
    .load_channel (load_channel),
    .payload_ok   (payload_ok),
    .switch_count (switch_count),
    .hop_ch0      (hop_ch0),
    .hop_ch1      (hop_ch1),
    .hop_ch2      (hop_ch2),
    .result       (step_result)
  );

  // Result buffer toward the sink.
  hsc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (step_result),
    .full       (full),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head       (head)
  );

  assign set_channel   = head.set_channel;
  assign channel       = head.channel;
  assign start_rx      = head.start_rx;
  assign stop_rx       = head.stop_rx;
  assign clear_timer   = head.clear_timer;
  assign load_compare  = head.load_compare;
  assign compare_value = head.compare_value;
  assign send_reply    = head.send_reply;
  assign mode          = head.mode;

endmodule
